/* sv/cims_pkg.sv */
`timescale 1ns / 1ps

package cims_pkg;

  // Multiplier counter and tolerance level widths
  localparam int TRIAL_W    = 20;
  localparam int LVL_W      = 3;
  localparam int COMP_W     = 2;
  localparam int NUM_COMP   = 3;

  // Common multiplier (product of the three per-value multipliers)
  localparam int DPROD_W    = 60;

  // Shared multiplier works on 16-bit digits of the padded common multiplier
  localparam int CHUNK_W    = 16;
  localparam int CHUNK_SH_W = 4;
  localparam int NUM_CHUNKS = 4;
  localparam int CHUNK_IDX_W = 2;
  localparam int BOP_W      = CHUNK_W * NUM_CHUNKS;

  localparam int SCALED_W   = 64;
  localparam int OUT_DATA_W = 256;
  localparam int OUT_USER_W = 1;

  localparam logic [COMP_W-1:0]      LAST_COMP  = COMP_W'(NUM_COMP - 1);
  localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(NUM_CHUNKS - 1);

  localparam logic [SCALED_W-1:0] SAT_MAX = {1'b0, {(SCALED_W-1){1'b1}}};
  localparam logic [SCALED_W-1:0] SAT_MIN = {1'b1, {(SCALED_W-1){1'b0}}};

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [LVL_W-1:0] TOL_RESET = 3'd5;
  localparam logic [LVL_W-1:0] TOL_MAX   = 3'd6;
  localparam logic [LVL_W-1:0] TOL_ILLEGAL = 3'd7;
  localparam logic REG_IDX_TOLERANCE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADC,
    S_SEARCH,
    S_MULD,
    S_SCALE,
    S_RND,
    S_OUT
  } state_t;

  typedef enum logic {
    MODE_DPROD,
    MODE_SCALE
  } mul_mode_t;

  typedef struct packed {
    logic                   load;
    logic                   load_comp;
    logic                   search;
    logic                   mul_step;
    mul_mode_t              mode;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic [COMP_W-1:0]      comp;
    logic                   rnd;
    logic                   out_load;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic out_busy;
  } stat_t;

  // Ten to the power of a tolerance level
  function automatic logic [TRIAL_W-1:0] pow10(input logic [LVL_W-1:0] k);
    logic [TRIAL_W-1:0] p;
    case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      default: p = 20'd1000000;
    endcase
    return p;
  endfunction

endpackage

/* sv/cims_ctrl.sv */
`timescale 1ns / 1ps

module cims_ctrl import cims_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t                 state_r, state_nxt;
  logic [COMP_W-1:0]      comp_r, comp_nxt;
  logic [CHUNK_IDX_W-1:0] chunk_r, chunk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r  <= '0;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    chunk_nxt = chunk_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.mode  = MODE_DPROD;
    cmd.comp  = comp_r;
    cmd.chunk = chunk_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          comp_nxt  = '0;
          state_nxt = S_LOADC;
        end
      end
      S_LOADC: begin
        cmd.load_comp = 1'b1;
        state_nxt     = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.pass) begin
          chunk_nxt = '0;
          state_nxt = S_MULD;
        end
      end
      S_MULD: begin
        cmd.mul_step = 1'b1;
        chunk_nxt    = chunk_r + 1'b1;
        if (chunk_r == LAST_CHUNK) begin
          if (comp_r == LAST_COMP) begin
            comp_nxt  = '0;
            state_nxt = S_SCALE;
          end else begin
            comp_nxt  = comp_r + 1'b1;
            state_nxt = S_LOADC;
          end
        end
      end
      S_SCALE: begin
        cmd.mul_step = 1'b1;
        cmd.mode     = MODE_SCALE;
        chunk_nxt    = chunk_r + 1'b1;
        if (chunk_r == LAST_CHUNK) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        chunk_nxt = '0;
        if (comp_r == LAST_COMP) begin
          state_nxt = S_OUT;
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = S_SCALE;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/cims_dpath.sv */
`timescale 1ns / 1ps

module cims_dpath import cims_pkg::*; #(
  parameter int FRACTION_BITS = 32,
  parameter int INTEGER_BITS  = 16,
  localparam int VB = INTEGER_BITS + FRACTION_BITS,
  localparam int PW = VB + BOP_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [NUM_COMP*VB-1:0] in_values,
  input  logic [LVL_W-1:0]      tol_exp,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [SCALED_W-1:0]   out_scaled [NUM_COMP],
  output logic [DPROD_W-1:0]    out_dprod,
  output logic                  out_ovf
);

  localparam int F = FRACTION_BITS;
  localparam logic [63:0] ONE_M1 = (64'd1 << F) - 64'd1;
  localparam logic [63:0] THR_0 = ONE_M1;
  localparam logic [63:0] THR_1 = ONE_M1 / 64'd10;
  localparam logic [63:0] THR_2 = ONE_M1 / 64'd100;
  localparam logic [63:0] THR_3 = ONE_M1 / 64'd1000;
  localparam logic [63:0] THR_4 = ONE_M1 / 64'd10000;
  localparam logic [63:0] THR_5 = ONE_M1 / 64'd100000;
  localparam logic [63:0] THR_6 = ONE_M1 / 64'd1000000;
  localparam logic [PW:0] HALF  = (PW+1)'(1) << (F - 1);

  logic [VB-1:0]       mag_r [NUM_COMP];
  logic                neg_r [NUM_COMP];
  logic [LVL_W-1:0]    lvl_r;
  logic [TRIAL_W-1:0]  m_r;
  logic [F-1:0]        acc_r;
  logic [DPROD_W-1:0]  d_r;
  logic [PW-1:0]       prod_r;
  logic [SCALED_W-1:0] res_r [NUM_COMP];
  logic                ovf_r;
  logic                out_tvalid_r;
  logic [SCALED_W-1:0] out_scaled_r [NUM_COMP];
  logic [DPROD_W-1:0]  out_dprod_r;
  logic                out_ovf_r;

  logic [VB-1:0]          mag_sel;
  logic                   neg_sel;
  logic [F-1:0]           frac_dist;
  logic [F-1:0]           thr;
  logic                   pass;
  logic [VB-1:0]          a_op;
  logic [BOP_W-1:0]       b_op;
  logic [CHUNK_W-1:0]     b_chunk;
  logic [VB+CHUNK_W-1:0]  partial;
  logic [5:0]             sh;
  logic [PW-1:0]          prod_nxt;
  logic [PW:0]            rnd_full;
  logic [SCALED_W-1:0]    q;
  logic                   q_hi;
  logic [SCALED_W-1:0]    rnd_res;
  logic                   rnd_ovf;

  always_comb begin
    case (cmd.comp)
      2'd0: begin
        mag_sel = mag_r[0];
        neg_sel = neg_r[0];
      end
      2'd1: begin
        mag_sel = mag_r[1];
        neg_sel = neg_r[1];
      end
      default: begin
        mag_sel = mag_r[2];
        neg_sel = neg_r[2];
      end
    endcase
  end

  // Closeness test against the nearest integer
  assign frac_dist = acc_r[F-1] ? ((~acc_r) + {{(F-1){1'b0}}, 1'b1}) : acc_r;

  always_comb begin
    case (lvl_r)
      3'd0:    thr = THR_0[F-1:0];
      3'd1:    thr = THR_1[F-1:0];
      3'd2:    thr = THR_2[F-1:0];
      3'd3:    thr = THR_3[F-1:0];
      3'd4:    thr = THR_4[F-1:0];
      3'd5:    thr = THR_5[F-1:0];
      default: thr = THR_6[F-1:0];
    endcase
  end

  assign pass = (frac_dist <= thr);

  // One 16-bit digit of the common multiplier per cycle
  assign a_op    = (cmd.mode == MODE_SCALE) ? mag_sel : VB'(m_r);
  assign b_op    = BOP_W'(d_r);
  assign b_chunk = b_op[cmd.chunk*CHUNK_W +: CHUNK_W];
  assign partial = a_op * b_chunk;
  assign sh      = {cmd.chunk, {CHUNK_SH_W{1'b0}}};
  assign prod_nxt = ((cmd.chunk == '0) ? '0 : prod_r) + (PW'(partial) << sh);

  // Round to nearest and saturate
  assign rnd_full = {1'b0, prod_r} + HALF;
  assign q        = rnd_full[F +: SCALED_W];
  assign q_hi     = |rnd_full[PW:F+SCALED_W];

  always_comb begin
    rnd_ovf = 1'b0;
    rnd_res = q;
    if (q_hi) begin
      rnd_ovf = 1'b1;
      rnd_res = neg_sel ? SAT_MIN : SAT_MAX;
    end else if (!neg_sel) begin
      if (q[SCALED_W-1]) begin
        rnd_ovf = 1'b1;
        rnd_res = SAT_MAX;
      end
    end else if (q > SAT_MIN) begin
      rnd_ovf = 1'b1;
      rnd_res = SAT_MIN;
    end else begin
      rnd_res = (~q) + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        neg_r[j] <= in_values[j*VB + VB - 1];
        mag_r[j] <= in_values[j*VB + VB - 1] ? ((~in_values[j*VB +: VB]) + VB'(1))
                                             : in_values[j*VB +: VB];
      end
      lvl_r <= tol_exp;
      d_r   <= DPROD_W'(1);
      ovf_r <= 1'b0;
    end
    if (cmd.load_comp) begin
      m_r   <= TRIAL_W'(1);
      acc_r <= mag_sel[F-1:0];
    end
    if (cmd.search && !pass) begin
      if ((m_r > pow10(lvl_r)) && (lvl_r != '0)) begin
        lvl_r <= lvl_r - 1'b1;
        m_r   <= TRIAL_W'(1);
        acc_r <= mag_sel[F-1:0];
      end else begin
        m_r   <= m_r + 1'b1;
        acc_r <= acc_r + mag_sel[F-1:0];
      end
    end
    if (cmd.mul_step) begin
      prod_r <= prod_nxt;
      if ((cmd.mode == MODE_DPROD) && (cmd.chunk == LAST_CHUNK)) begin
        d_r <= prod_nxt[DPROD_W-1:0];
      end
    end
    if (cmd.rnd) begin
      res_r[cmd.comp] <= rnd_res;
      ovf_r           <= ovf_r | rnd_ovf;
    end
    if (cmd.out_load) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        out_scaled_r[j] <= res_r[j];
      end
      out_dprod_r <= d_r;
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign stat.pass     = pass;
  assign stat.out_busy = out_tvalid_r && !out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_scaled = out_scaled_r;
  assign out_dprod  = out_dprod_r;
  assign out_ovf    = out_ovf_r;

endmodule

/* sv/common_integer_multiplier_search_unit.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake          | Contents
// in_      | in  | in_tvalid/tready   | tdata: value_x, value_y, value_z (signed fixed point)
// out_     | out | out_tvalid/tready  | tdata: scaled_x/y/z, common_multiplier; tuser: overflow
// cfg_     | in  | psel/penable/pwrite| tolerance_exponent at byte address 0, pready always high
//
// An item passes through these steps: accept; per value a load, the closeness trials (one trial
// multiplier per cycle) and the four 16-bit digits on the shared multiplier; per value the four
// scaling digits and one rounding step; and one output load, which waits while a stalled result
// holds the register.
// Reset is synchronous and active low; it clears the controller and the output valid.
// A new input transaction is taken while a finished result still waits in the output register.

module common_integer_multiplier_search_unit import cims_pkg::*; #(
  parameter int FRACTION_BITS = 32,
  parameter int INTEGER_BITS  = 16,
  localparam int VALUE_BITS = INTEGER_BITS + FRACTION_BITS,
  localparam int IN_DATA_W  = ((NUM_COMP * VALUE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // value_x, value_y, value_z from bit 0 up, then zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // scaled_x, scaled_y, scaled_z, common_multiplier from bit 0 up, then zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // overflow_flag
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [LVL_W-1:0]    tol_r;
  logic [LVL_W-1:0]    tol_nxt;
  logic                cfg_wr;
  cmd_t                cmd;
  stat_t               stat;
  logic [SCALED_W-1:0] scaled [NUM_COMP];
  logic [DPROD_W-1:0]  dprod;
  logic                ovf;

  // Register file: one word, paddr[2] picks the register, low bits are byte offset
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Clamp an exponent of seven down to six
  assign tol_nxt = (cfg_pwdata[LVL_W-1:0] == TOL_ILLEGAL) ? TOL_MAX : cfg_pwdata[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_IDX_TOLERANCE)) begin
      tol_r <= tol_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_TOLERANCE) ? CFG_DATA_W'(tol_r) : '0;

  // Sequence the search, the common multiplier update, scaling and output load
  cims_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Trial accumulator, closeness test, shared multiplier, rounding and result registers
  cims_dpath #(
    .FRACTION_BITS (FRACTION_BITS),
    .INTEGER_BITS  (INTEGER_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_values  (in_tdata[NUM_COMP*VALUE_BITS-1:0]),
    .tol_exp    (tol_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_scaled (scaled),
    .out_dprod  (dprod),
    .out_ovf    (ovf)
  );

  assign out_tdata = {{(OUT_DATA_W - NUM_COMP*SCALED_W - DPROD_W){1'b0}},
                      dprod, scaled[2], scaled[1], scaled[0]};
  assign out_tuser = ovf;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Testbench for common_integer_multiplier_search_unit. A short table of hand-picked value
// triples runs first, then randomized phases, each with its own tolerance setting and
// handshake idling. Every result is checked field by field against hand-written values or
// against a behavioral model of the multiplier search kept in this file.
module testbench;
  import cims_pkg::*;

  localparam int FRAC_BITS      = 32;
  localparam int VAL_W          = 48;
  localparam int IN_W           = 3 * VAL_W;
  // Slowest gap between transactions: one item at level 5 runs about 3 * 100001 trials.
  localparam int WATCHDOG_LIMIT = 1_200_000;
  localparam int LONG_HOLD      = 400;
  localparam int END_CYCLES     = 64;
  localparam int NUM_PHASES     = 7;
  localparam logic [CFG_ADDR_W-1:0] TOL_ADDR = CFG_ADDR_W'(4 * int'(REG_IDX_TOLERANCE));
  localparam logic [63:0] FRAC_ONE = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [SCALED_W-1:0] sx;
    logic [SCALED_W-1:0] sy;
    logic [SCALED_W-1:0] sz;
    logic [DPROD_W-1:0]  mult;
    logic                ovf;
  } result_t;

  typedef struct packed {
    logic [IN_W-1:0] data;
    bit              typed;
    result_t         want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  // value_x, value_y, value_z from bit 0 up
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // scaled_x, scaled_y, scaled_z, common_multiplier from bit 0 up, then zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  // overflow_flag
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  result_t     pending_results[$];
  row_t        directed_rows[$];
  int unsigned tol_setting = TOL_RESET;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  common_integer_multiplier_search_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Behavioral model
  // ---------------------------------------------------------------------------------------

  // Smallest m >= 1 that brings m*|v| within 10^-level of an integer. The level drops by
  // one (coarser tolerance) when m passes 10^level, and the drop sticks for later values.
  function automatic logic [63:0] find_multiplier(input logic [63:0] mag,
                                                  inout int unsigned level);
    logic [63:0] m, frac, gap, limit;
    bit          hit;
    int          i;
    m = 0;
    hit = 0;
    limit = 1;
    for (i = 0; i < int'(level); i++) limit = limit * 10;
    while (!hit) begin
      m = m + 1;
      // only the fraction bits matter, so wrapping of the product is harmless
      frac = (m * mag) & (FRAC_ONE - 1);
      gap = (frac < FRAC_ONE - frac) ? frac : FRAC_ONE - frac;
      if (gap * limit < FRAC_ONE) begin
        hit = 1;
      end else if (m > limit && level > 0) begin
        level = level - 1;
        limit = limit / 10;
        m = 0;
      end
    end
    return m;
  endfunction

  // |v| * d rounded to nearest (ties away from zero), signed and saturated to 64 bits
  function automatic logic [63:0] scale_value(input logic [63:0] mag, input bit neg,
                                              input logic [63:0] d, inout bit ovf);
    logic [127:0] prod;
    logic [63:0]  q;
    prod = {64'd0, mag} * {64'd0, d} + (128'd1 << (FRAC_BITS - 1));
    if (prod[127:64+FRAC_BITS] != 0) begin
      ovf = 1;
      return neg ? SAT_MIN : SAT_MAX;
    end
    q = prod[64+FRAC_BITS-1:FRAC_BITS];
    if (!neg) begin
      if (q > SAT_MAX) begin
        ovf = 1;
        return SAT_MAX;
      end
      return q;
    end
    if (q > SAT_MIN) begin
      ovf = 1;
      return SAT_MIN;
    end
    return ~q + 64'd1;
  endfunction

  function automatic result_t predict_scaling(input logic [IN_W-1:0] data,
                                              input int unsigned start_level);
    logic [63:0]      mag[3];
    bit               neg[3];
    logic [63:0]      d;
    logic [VAL_W-1:0] v;
    int unsigned      level;
    bit               ovf;
    result_t          r;
    int               j;
    level = start_level;
    d = 1;
    ovf = 0;
    for (j = 0; j < 3; j++) begin
      v = data[j*VAL_W +: VAL_W];
      neg[j] = v[VAL_W-1];
      // the most negative input maps to 2^47, which still fits the magnitude
      mag[j] = {16'd0, neg[j] ? ~v + 1'b1 : v};
      d = d * find_multiplier(mag[j], level);
    end
    r.sx = scale_value(mag[0], neg[0], d, ovf);
    r.sy = scale_value(mag[1], neg[1], d, ovf);
    r.sz = scale_value(mag[2], neg[2], d, ovf);
    r.mult = d[DPROD_W-1:0];
    r.ovf = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Value construction
  // ---------------------------------------------------------------------------------------

  function automatic logic [VAL_W-1:0] fixv(input longint ip, input longint unsigned fr);
    return VAL_W'((ip <<< FRAC_BITS) + fr);
  endfunction

  // Fraction bits of p/q, rounded
  function automatic longint unsigned frac_of(input int unsigned p, input int unsigned q);
    return ((64'(p) << FRAC_BITS) + 64'(q / 2)) / 64'(q);
  endfunction

  // Mostly rationals with small denominators, so the search ends within q trials at any
  // level; raw bit patterns only where the level keeps the worst case short.
  function automatic logic [VAL_W-1:0] random_value(input bit allow_noise);
    int unsigned      q, p;
    logic [VAL_W-1:0] mag;
    if (allow_noise && $urandom_range(3) == 0) return VAL_W'({$urandom, $urandom});
    q = ($urandom_range(9) == 0) ? $urandom_range(1000, 1) : $urandom_range(16, 1);
    p = $urandom_range(q - 1, 0);
    mag = VAL_W'((64'($urandom_range(32767, 0)) << FRAC_BITS) + frac_of(p, q));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic add_row(input logic [VAL_W-1:0] x, y, z, input bit typed,
                         input logic [63:0] sx, sy, sz, input logic [DPROD_W-1:0] mult);
    row_t r;
    r.data = {z, y, x};
    r.typed = typed;
    r.want.sx = sx;
    r.want.sy = sy;
    r.want.sz = sz;
    r.want.mult = mult;
    r.want.ovf = 1'b0;
    directed_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------------------
  // Bus tasks (all start and end on a falling edge)
  // ---------------------------------------------------------------------------------------

  task automatic send_values(input logic [IN_W-1:0] data, input result_t want);
    // idle the input channel at random before offering the transaction
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= data;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_tolerance(input int unsigned val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= TOL_ADDR;
    cfg_pwdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // writes above the top level saturate to it
    tol_setting = ((val & 7) > TOL_MAX) ? TOL_MAX : (val & 7);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: stall at random, or hold off for a counted stretch on request
  // ---------------------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, got %h / %h", $time, out_tdata,
                 out_tuser);
      end else begin
        want = pending_results.pop_front();
        check_field("scaled_x", want.sx, out_tdata[0 +: SCALED_W]);
        check_field("scaled_y", want.sy, out_tdata[SCALED_W +: SCALED_W]);
        check_field("scaled_z", want.sz, out_tdata[2*SCALED_W +: SCALED_W]);
        check_field("common_multiplier", 64'(want.mult), 64'(out_tdata[3*SCALED_W +: DPROD_W]));
        check_field("overflow_flag", 64'(want.ovf), 64'(out_tuser[0]));
      end
    end
  end

  // Watchdog: end the run when no transaction moves on any port for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  initial begin
    row_t             r;
    result_t          want;
    logic [IN_W-1:0]  data;
    int unsigned      new_tol, n_items;
    int               ph, i;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, run at the reset tolerance level of 5
    // all zero: every multiplier is 1
    add_row('0, '0, '0, 1, 64'd0, 64'd0, 64'd0, 60'd1);
    // whole numbers pass at once
    add_row(fixv(1, 0), fixv(-1, 0), fixv(32767, 0), 1, 64'd1, -64'd1, 64'd32767, 60'd1);
    // largest, most negative and minus one step: all pass at m = 1
    add_row(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 1,
            64'd32768, -64'd32768, 64'd0, 60'd1);
    // halves and quarters: multipliers 2, 4, 4
    add_row(fixv(0, 32'h8000_0000), -fixv(0, 32'h4000_0000), fixv(0, 32'hC000_0000), 1,
            64'd16, -64'd8, 64'd24, 60'd32);
    // closeness boundary at level 5: distance 42949 passes, 42950 fails
    add_row(fixv(0, 42949), fixv(0, 42950), fixv(-5, 42949), 0, '0, '0, '0, '0);
    // just above one half, one step above the bottom of the range, and 32767.5
    add_row(fixv(0, 32'h8000_0001), fixv(-32768, 1), fixv(32767, 32'h8000_0000), 0,
            '0, '0, '0, '0);
    // thirds, sevenths and elevenths with integer parts
    add_row(fixv(0, frac_of(1, 3)), -fixv(2, frac_of(2, 7)), fixv(100, frac_of(5, 11)), 0,
            '0, '0, '0, '0);
    // large multipliers near 80000 each: every scaled field saturates
    add_row(fixv(32767, frac_of(1, 80021)), -fixv(32767, frac_of(1, 80039)),
            fixv(32767, frac_of(1, 80051)), 0, '0, '0, '0, '0);

    foreach (directed_rows[k]) begin
      r = directed_rows[k];
      want = r.typed ? r.want : predict_scaling(r.data, tol_setting);
      send_values(r.data, want);
    end

    // Randomized phases: tolerance setting, item count and idling per phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin new_tol = 1;           n_items = 20; idle_pct = 0;  stall_pct = 0;  end
        1: begin new_tol = TOL_MAX;     n_items = 12; idle_pct = 58; stall_pct = 0;  end
        2: begin new_tol = 3;           n_items = 16; idle_pct = 0;  stall_pct = 58; end
        3: begin new_tol = 0;           n_items = 12; idle_pct = 29; stall_pct = 29; end
        4: begin new_tol = TOL_ILLEGAL; n_items = 10; idle_pct = 29; stall_pct = 29; end
        5: begin new_tol = 2;           n_items = 16; idle_pct = 0;  stall_pct = 0;  end
        default: begin new_tol = 4;     n_items = 14; idle_pct = 58; stall_pct = 58; end
      endcase
      drain_results();
      write_tolerance(new_tol);
      // hold off the result side long enough for the block to fill and stall its input
      if (ph == 0) hold_left = LONG_HOLD;
      for (i = 0; i < int'(n_items); i++) begin
        // pause the sender halfway until every result is back
        if (ph == 5 && i == int'(n_items) / 2) drain_results();
        data = {random_value(tol_setting <= 4), random_value(tol_setting <= 4),
                random_value(tol_setting <= 4)};
        send_values(data, predict_scaling(data, tol_setting));
      end
    end

    drain_results();
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/cims_pkg.sv
sv/cims_ctrl.sv
sv/cims_dpath.sv
sv/common_integer_multiplier_search_unit.sv
tb/testbench.sv
